// ===== rtl/mve_pkg.sv =====
// Shared types and constants of the MessagePack value encoder.
`default_nettype none
package mve_pkg;

  localparam int CMD_W   = 4;
  localparam int OPER_W  = 64;
  localparam int CAP_W   = 13;
  localparam int POS_W   = 13;
  localparam int NB_W    = 4;
  localparam int SUM_W   = 18;

  localparam logic [CMD_W-1:0] CMD_UINT    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SINT    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ARRAY   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MAP     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STR     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_BOOL    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FLOAT   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RAW     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_RESTART = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ROOM  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;

  localparam logic [7:0] HD_UINT8   = 8'hcc;
  localparam logic [7:0] HD_UINT16  = 8'hcd;
  localparam logic [7:0] HD_UINT32  = 8'hce;
  localparam logic [7:0] HD_UINT64  = 8'hcf;
  localparam logic [7:0] HD_INT8    = 8'hd0;
  localparam logic [7:0] HD_INT16   = 8'hd1;
  localparam logic [7:0] HD_INT32   = 8'hd2;
  localparam logic [7:0] HD_INT64   = 8'hd3;
  localparam logic [7:0] HD_FIXARR  = 8'h90;
  localparam logic [7:0] HD_ARR16   = 8'hdc;
  localparam logic [7:0] HD_FIXMAP  = 8'h80;
  localparam logic [7:0] HD_MAP16   = 8'hde;
  localparam logic [7:0] HD_FIXSTR  = 8'ha0;
  localparam logic [7:0] HD_STR8    = 8'hd9;
  localparam logic [7:0] HD_STR16   = 8'hda;
  localparam logic [7:0] HD_TRUE    = 8'hc3;
  localparam logic [7:0] HD_FALSE   = 8'hc2;
  localparam logic [7:0] HD_FLOAT32 = 8'hca;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // One queued run: header byte, then nbytes of value, most significant first.
  // A run without data is a single status transfer.
  typedef struct packed {
    logic [7:0]        head;
    logic [OPER_W-1:0] value;
    logic [NB_W-1:0]   nbytes;
    logic              data;
    logic [1:0]        status;
  } mve_entry_t;

endpackage
`default_nettype wire

// ===== rtl/messagepack_value_encoder.sv =====
// Top level of the MessagePack value encoder.
// Each accepted command produces a run of transfers, one byte each, holding the
// shortest MessagePack encoding (header first, value bytes most significant
// first); a failed check, a restart or an unknown command code produces one status transfer instead.
// The front end takes a command every cycle while its two-entry queue has room;
// the back end sends one transfer per cycle while result_stall does not hold it, so
// sustained throughput is set by the run length per command: one transfer for
// fixints, bool, raw bytes and status, up to nine for a 64-bit integer.
// The room check covers the whole run (plus the body for a string header)
// against the smaller of the capacity register and BUFFER_BYTES.
`default_nettype none
module messagepack_value_encoder #(
  parameter int BUFFER_BYTES = 4096
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [12:0] cfg_wr_data,
  input  wire         cmd_valid,
  output logic        cmd_stall,
  input  wire  [3:0]  cmd,
  input  wire  [63:0] operand,
  output logic        result_valid,
  input  wire         result_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [1:0]  status
);
  import mve_pkg::*;

  mve_entry_t front_entry;
  mve_entry_t q_head;
  logic       q_full;
  logic       q_nonempty;
  logic       q_pop;
  logic       accept;

  assign cmd_stall = q_full;
  assign accept    = cmd_valid && !q_full;

  mve_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .cmd         (cmd),
    .operand     (operand),
    .entry       (front_entry)
  );

  mve_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head),
    .nonempty  (q_nonempty)
  );

  mve_back u_back (
    .clk          (clk),
    .rst          (rst),
    .run          (q_head),
    .run_valid    (q_nonempty),
    .run_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status)
  );

endmodule
`default_nettype wire

// ===== rtl/mve_front.sv =====
// Front end: capacity register, command classification, room check, write position.
`default_nettype none
module mve_front #(
  parameter int BUFFER_BYTES = 4096
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_wr_en,
  input  wire [12:0]               cfg_wr_data,
  input  wire                      accept,
  input  wire [3:0]                cmd,
  input  wire [63:0]               operand,
  output mve_pkg::mve_entry_t      entry
);
  import mve_pkg::*;

  localparam logic [SUM_W-1:0] BUF_LIM = SUM_W'(BUFFER_BYTES);

  logic [CAP_W-1:0] capacity;
  logic [POS_W-1:0] write_position;
  logic [POS_W-1:0] write_position_next;

  logic [7:0]        head;
  logic [NB_W-1:0]   nb;
  logic              enc;
  logic              cnt_err;
  logic              restart;
  logic [15:0]       extra;
  logic [SUM_W-1:0]  usable;
  logic [SUM_W-1:0]  total;
  logic              no_room;

  always_comb begin
    head    = operand[7:0];
    nb      = '0;
    enc     = 1'b1;
    cnt_err = 1'b0;
    restart = 1'b0;
    extra   = '0;
    case (cmd)
      CMD_UINT, CMD_SINT: begin
        if (cmd == CMD_SINT && operand[63]) begin
          if (&operand[63:5]) begin
            head = operand[7:0];
          end else if (&operand[63:7]) begin
            head = HD_INT8;
            nb   = 4'd1;
          end else if (&operand[63:15]) begin
            head = HD_INT16;
            nb   = 4'd2;
          end else if (&operand[63:31]) begin
            head = HD_INT32;
            nb   = 4'd4;
          end else begin
            head = HD_INT64;
            nb   = 4'd8;
          end
        end else begin
          if (operand[63:7] == '0) begin
            head = operand[7:0];
          end else if (operand[63:8] == '0) begin
            head = HD_UINT8;
            nb   = 4'd1;
          end else if (operand[63:16] == '0) begin
            head = HD_UINT16;
            nb   = 4'd2;
          end else if (operand[63:32] == '0) begin
            head = HD_UINT32;
            nb   = 4'd4;
          end else begin
            head = HD_UINT64;
            nb   = 4'd8;
          end
        end
      end
      CMD_ARRAY, CMD_MAP: begin
        cnt_err = (operand[63:16] != '0);
        if (operand[15:4] == '0) begin
          head = (cmd == CMD_ARRAY ? HD_FIXARR : HD_FIXMAP) | {4'h0, operand[3:0]};
        end else begin
          head = (cmd == CMD_ARRAY) ? HD_ARR16 : HD_MAP16;
          nb   = 4'd2;
        end
      end
      CMD_STR: begin
        cnt_err = (operand[63:16] != '0);
        extra   = operand[15:0];
        if (operand[15:5] == '0) begin
          head = HD_FIXSTR | {3'h0, operand[4:0]};
        end else if (operand[15:8] == '0) begin
          head = HD_STR8;
          nb   = 4'd1;
        end else begin
          head = HD_STR16;
          nb   = 4'd2;
        end
      end
      CMD_BOOL: begin
        head = (operand != '0) ? HD_TRUE : HD_FALSE;
      end
      CMD_FLOAT: begin
        head = HD_FLOAT32;
        nb   = 4'd4;
      end
      CMD_RAW: begin
        head = operand[7:0];
      end
      CMD_RESTART: begin
        enc     = 1'b0;
        restart = 1'b1;
      end
      default: begin
        enc = 1'b0;
      end
    endcase
  end

  always_comb begin
    usable  = (SUM_W'(capacity) > BUF_LIM) ? BUF_LIM : SUM_W'(capacity);
    total   = SUM_W'(write_position) + SUM_W'(nb) + SUM_W'(1) + SUM_W'(extra);
    no_room = (total > usable);
  end

  always_comb begin
    entry.head   = head;
    entry.value  = operand;
    entry.nbytes = nb;
    entry.data   = enc && !cnt_err && !no_room;
    entry.status = ST_OK;
    if (enc && cnt_err) begin
      entry.status = ST_COUNT;
    end else if (enc && no_room) begin
      entry.status = ST_ROOM;
    end
    write_position_next = write_position;
    if (restart) begin
      write_position_next = '0;
    end else if (entry.data) begin
      write_position_next = write_position + POS_W'(nb) + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RESET;
      write_position <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (accept) begin
        write_position <= write_position_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mve_queue.sv =====
// Two-entry queue of classified runs between front and back.
`default_nettype none
module mve_queue (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  input  wire mve_pkg::mve_entry_t  push_data,
  output logic                      full,
  input  wire                       pop,
  output mve_pkg::mve_entry_t       head_data,
  output logic                      nonempty
);
  import mve_pkg::*;

  mve_entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign nonempty  = (count != 2'd0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mve_back.sv =====
// Back end: serializes one queued run a byte per transfer into the output register.
`default_nettype none
module mve_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire mve_pkg::mve_entry_t  run,
  input  wire                       run_valid,
  output logic                      run_pop,
  output logic                      result_valid,
  input  wire                       result_stall,
  output logic [7:0]                out_byte,
  output logic                      byte_valid,
  output logic                      last,
  output logic [1:0]                status
);
  import mve_pkg::*;

  logic [NB_W-1:0] idx;
  logic [NB_W-1:0] idx_next;
  logic [NB_W-1:0] diff;
  logic [5:0]      bit_lo;
  logic            load;
  logic            is_last;
  logic [7:0]      byte_sel;

  always_comb begin
    load     = run_valid && (!result_valid || !result_stall);
    diff     = run.nbytes - idx;
    bit_lo   = {diff[2:0], 3'b000};
    byte_sel = (idx == '0) ? run.head : run.value[bit_lo +: 8];
    is_last  = !run.data || (idx == run.nbytes);
    run_pop  = load && is_last;
    idx_next = is_last ? '0 : idx + NB_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx          <= idx_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= run.data ? byte_sel : 8'h00;
      byte_valid <= run.data;
      last       <= is_last;
      status     <= run.status;
    end
  end

endmodule
`default_nettype wire

// ===== sim/mve_checker.sv =====
// Checker for the MessagePack value encoder: predicts each command's byte run and compares.
module mve_checker #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  logic [3:0]  cmd,
  input  logic [63:0] operand,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        last,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mve_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       fin;
    logic [1:0] st;
  } xfer_t;

  xfer_t            expected_xfers[$];
  xfer_t            seen;
  logic [CAP_W-1:0] capacity_reg;
  logic [POS_W-1:0] write_pos;

  task automatic push_status(input logic [1:0] st);
    expected_xfers.push_back(xfer_t'{8'h00, 1'b0, 1'b1, st});
  endtask

  task automatic size_unsigned(input logic [63:0] v, output logic [7:0] hd, output int nb);
    if (v <= 64'h7f) begin
      hd = v[7:0];
      nb = 0;
    end else if (v <= 64'hff) begin
      hd = HD_UINT8;
      nb = 1;
    end else if (v <= 64'hffff) begin
      hd = HD_UINT16;
      nb = 2;
    end else if (v <= 64'hffff_ffff) begin
      hd = HD_UINT32;
      nb = 4;
    end else begin
      hd = HD_UINT64;
      nb = 8;
    end
  endtask

  task automatic encode_command(input logic [3:0] c, input logic [63:0] v);
    logic [7:0]  hd;
    logic [63:0] val;
    int          nb;
    int          body;
    int          usable;
    hd   = 8'h00;
    nb   = 0;
    body = 0;
    val  = v;
    case (c)
      CMD_UINT: size_unsigned(v, hd, nb);
      CMD_SINT: begin
        if (!v[63]) size_unsigned(v, hd, nb);
        else if (v >= 64'hffff_ffff_ffff_ffe0) hd = v[7:0];
        else if (v >= 64'hffff_ffff_ffff_ff80) begin
          hd = HD_INT8;
          nb = 1;
        end else if (v >= 64'hffff_ffff_ffff_8000) begin
          hd = HD_INT16;
          nb = 2;
        end else if (v >= 64'hffff_ffff_8000_0000) begin
          hd = HD_INT32;
          nb = 4;
        end else begin
          hd = HD_INT64;
          nb = 8;
        end
      end
      CMD_ARRAY, CMD_MAP: begin
        if (v > 64'hffff) begin
          push_status(ST_COUNT);
          return;
        end
        if (v <= 64'hf) hd = ((c == CMD_ARRAY) ? HD_FIXARR : HD_FIXMAP) | v[7:0];
        else begin
          hd = (c == CMD_ARRAY) ? HD_ARR16 : HD_MAP16;
          nb = 2;
        end
      end
      CMD_STR: begin
        if (v > 64'hffff) begin
          push_status(ST_COUNT);
          return;
        end
        if (v <= 64'd31) hd = HD_FIXSTR | v[7:0];
        else if (v <= 64'hff) begin
          hd = HD_STR8;
          nb = 1;
        end else begin
          hd = HD_STR16;
          nb = 2;
        end
        body = int'(v[15:0]);
      end
      CMD_BOOL: hd = (v != 64'd0) ? HD_TRUE : HD_FALSE;
      CMD_FLOAT: begin
        hd  = HD_FLOAT32;
        nb  = 4;
        val = {32'h0, v[31:0]};
      end
      CMD_RAW: hd = v[7:0];
      CMD_RESTART: begin
        write_pos = '0;
        push_status(ST_OK);
        return;
      end
      default: begin
        push_status(ST_OK);
        return;
      end
    endcase
    usable = (int'(capacity_reg) > BUFFER_BYTES) ? BUFFER_BYTES : int'(capacity_reg);
    if (int'(write_pos) + nb + 1 + body > usable) begin
      push_status(ST_ROOM);
      return;
    end
    write_pos = write_pos + POS_W'(nb + 1);
    expected_xfers.push_back(xfer_t'{hd, 1'b1, nb == 0, ST_OK});
    for (int i = nb - 1; i >= 0; i--)
      expected_xfers.push_back(xfer_t'{val[8*i +: 8], 1'b1, i == 0, ST_OK});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity_reg = CAP_RESET;
      write_pos    = '0;
      fail_count   = 0;
      expected_xfers.delete();
    end else begin
      if (cfg_wr_en) capacity_reg = cfg_wr_data;
      if (cmd_valid && !cmd_stall) encode_command(cmd, operand);
      if (result_valid && !result_stall) begin
        if (expected_xfers.size() == 0) begin
          $error("unexpected transfer: out_byte %0h status %0d", out_byte, status);
          fail_count++;
        end else begin
          seen = expected_xfers.pop_front();
          if (out_byte !== seen.data) begin
            $error("out_byte expected %0h actual %0h", seen.data, out_byte);
            fail_count++;
          end
          if (byte_valid !== seen.dv) begin
            $error("byte_valid expected %0d actual %0d", seen.dv, byte_valid);
            fail_count++;
          end
          if (last !== seen.fin) begin
            $error("last expected %0d actual %0d", seen.fin, last);
            fail_count++;
          end
          if (status !== seen.st) begin
            $error("status expected %0d actual %0d", seen.st, status);
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_xfers.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the MessagePack value encoder: stimulus, idling phases and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mve_pkg::*;

  localparam int         BUFFER_BYTES   = 4096;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [3:0] CMD_CODE_MAX   = 4'hf;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_wr_en    = 1'b0;
  logic [12:0] cfg_wr_data  = '0;
  logic        cmd_valid    = 1'b0;
  logic [3:0]  cmd          = '0;
  logic [63:0] operand      = '0;
  logic        result_stall = 1'b0;
  logic        cmd_stall;
  logic        result_valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  status;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  logic [12:0] phase_caps [8] = '{13'd0, 13'd9, 13'd40, 13'd8191,
                                  13'd4096, 13'd1, 13'd4097, 13'd4095};

  messagepack_value_encoder #(.BUFFER_BYTES(BUFFER_BYTES)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .operand      (operand),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status)
  );

  mve_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .operand      (operand),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[messagepack_value_encoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [3:0] c, input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    operand   <= v;
    do @(posedge clk); while (cmd_stall);
    items_sent++;
  endtask

  // hold off commands until every expected transfer is back
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_capacity(input logic [12:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [63:0] rand_operand();
    int          k;
    logic [63:0] v;
    k = $urandom_range(64);
    v = {$urandom, $urandom};
    if (k < 64) v &= (64'd1 << k) - 64'd1;
    case ($urandom_range(7))
      0: v = (64'd1 << k) - 64'd1;
      1: v = 64'd1 << k;
      2, 3: v = ~v;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_count();
    case ($urandom_range(9))
      6, 7: return 64'($urandom_range(65535));
      8: return 64'hffff + 64'($urandom_range(2));
      9: return rand_operand() | (64'd1 << $urandom_range(63, 16));
      default: return 64'($urandom_range(20));
    endcase
  endfunction

  task automatic random_item();
    logic [63:0] n;
    int          r;
    r = $urandom_range(99);
    if (r < 18) send_cmd(CMD_UINT, rand_operand());
    else if (r < 36) send_cmd(CMD_SINT, rand_operand());
    else if (r < 44) send_cmd(CMD_ARRAY, rand_count());
    else if (r < 50) send_cmd(CMD_MAP, rand_count());
    else if (r < 62) begin
      n = rand_count();
      send_cmd(CMD_STR, n);
      if (n <= 64'd48)
        for (int i = 0; i < int'(n); i++) send_cmd(CMD_RAW, {$urandom, $urandom});
    end
    else if (r < 68) send_cmd(CMD_BOOL, $urandom_range(1) ? 64'd0 : rand_operand());
    else if (r < 76) send_cmd(CMD_FLOAT, {$urandom, $urandom});
    else if (r < 88) send_cmd(CMD_RAW, {$urandom, $urandom});
    else if (r < 95) send_cmd(CMD_RESTART, rand_operand());
    else send_cmd(4'($urandom_range(CMD_CODE_MAX, CMD_RESTART + 1)), rand_operand());
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_cmd(CMD_UINT, 64'd0);
    send_cmd(CMD_UINT, 64'h80);
    send_cmd(CMD_UINT, 64'hffff);
    send_cmd(CMD_UINT, 64'h1_0000_0000);
    send_cmd(CMD_UINT, 64'hffff_ffff_ffff_ffff);
    send_cmd(CMD_SINT, 64'hffff_ffff_ffff_ffe0);
    send_cmd(CMD_SINT, 64'hffff_ffff_ffff_ffdf);
    send_cmd(CMD_SINT, 64'hffff_ffff_ffff_7fff);
    send_cmd(CMD_SINT, 64'h8000_0000_0000_0000);
    send_cmd(CMD_SINT, 64'h7fff_ffff_ffff_ffff);
    send_cmd(CMD_ARRAY, 64'd15);
    send_cmd(CMD_ARRAY, 64'd16);
    send_cmd(CMD_MAP, 64'hffff);
    send_cmd(CMD_MAP, 64'h1_0000);
    send_cmd(CMD_STR, 64'd31);
    send_cmd(CMD_STR, 64'd32);
    send_cmd(CMD_STR, 64'd256);
    send_cmd(CMD_STR, 64'd70000);
    send_cmd(CMD_BOOL, 64'd0);
    send_cmd(CMD_BOOL, 64'h8000_0000_0000_0000);
    send_cmd(CMD_FLOAT, 64'hdead_beef_3f80_0000);
    send_cmd(CMD_RAW, 64'hffff_ffff_ffff_ffff);
    send_cmd(CMD_RESTART, 64'd0);
    send_cmd(CMD_RESTART + 4'd1, 64'd0);
    send_cmd(CMD_CODE_MAX, 64'hffff_ffff_ffff_ffff);

    for (int p = 0; p < 8; p++) begin
      send_idle_pct = 0;
      stall_pct     = 0;
      write_capacity(phase_caps[p]);
      case (p % 4)
        1: send_idle_pct = 59;
        2: stall_pct = 59;
        3: begin
          send_idle_pct = 28;
          stall_pct     = 28;
        end
        default: ;
      endcase
      // string bodies right at the buffer limit, with capacity above it
      if (phase_caps[p] == 13'd8191) begin
        send_cmd(CMD_RESTART, 64'd0);
        send_cmd(CMD_STR, 64'd4093);
        send_cmd(CMD_RESTART, 64'd0);
        send_cmd(CMD_STR, 64'd4094);
      end
      target = items_sent + 50;
      while (items_sent < target - 25) random_item();
      if (p % 4 == 1) drain();
      while (items_sent < target) random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[messagepack_value_encoder] OK");
    end else begin
      $display("[messagepack_value_encoder] ERROR");
    end
    $finish;
  end

endmodule
